// File: rtl/core/vic_pkg.sv
`timescale 1ns / 1ps

package vic_pkg;

	localparam int NUM_SOURCES_DEF = 32;
	localparam int NUM_SLOTS_DEF = 16;
	localparam int STACK_DEPTH = 17;
	localparam int LEVEL_W = 5;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SOURCE = 2'd2;

	localparam logic [9:0] REG_IRQ_STATUS = 10'd0;
	localparam logic [9:0] REG_FIQ_STATUS = 10'd1;
	localparam logic [9:0] REG_RAW_STATUS = 10'd2;
	localparam logic [9:0] REG_SELECT = 10'd3;
	localparam logic [9:0] REG_ENABLE = 10'd4;
	localparam logic [9:0] REG_ENABLE_CLR = 10'd5;
	localparam logic [9:0] REG_SOFT = 10'd6;
	localparam logic [9:0] REG_SOFT_CLR = 10'd7;
	localparam logic [9:0] REG_VECT_ADDR = 10'd12;
	localparam logic [9:0] REG_DEF_VECT = 10'd13;
	localparam logic [3:0] SLOT_VEC_PAGE = 4'd1;
	localparam logic [3:0] SLOT_CTL_PAGE = 4'd2;
	localparam logic [6:0] ID_PAGE = 7'h7f;

	localparam int CTL_ENABLE_BIT = 5;

	typedef struct packed {
		logic found;
		logic [LEVEL_W-1:0] level;
		logic [31:0] vec;
		logic [31:0] nonvect;
	} carry_t;

	typedef struct packed {
		logic [31:0] irqs;
		logic stack_empty;
		logic [LEVEL_W-1:0] top_level;
	} scan_ctx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN1 = 4'b0010,
		ST_ACCESS = 4'b0100,
		ST_SCAN2 = 4'b1000
	} state_t;

	function automatic logic [31:0] id_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h90;
			3'd1: b = 8'h11;
			3'd2: b = 8'h04;
			3'd3: b = 8'h00;
			3'd4: b = 8'h0d;
			3'd5: b = 8'hf0;
			3'd6: b = 8'h05;
			3'd7: b = 8'hb1;
			default: b = 8'h00;
		endcase
		return {24'd0, b};
	endfunction

endpackage

// File: rtl/core/vic_cell.sv
`timescale 1ns / 1ps

module vic_cell #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic wr_vec,
	input logic wr_ctl,
	input logic [31:0] wdata,
	input vic_pkg::scan_ctx_t ctx,
	input vic_pkg::carry_t carry_in,
	output vic_pkg::carry_t carry_out,
	output logic [5:0] ctl,
	output logic [31:0] vec
);

	logic [5:0] ctl_q;
	logic [31:0] vec_q;
	vic_pkg::carry_t carry_q;
	vic_pkg::carry_t nxt;
	logic eligible;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			vec_q <= '0;
		end else begin
			if (wr_ctl) begin
				ctl_q <= wdata[5:0];
			end
			if (wr_vec) begin
				vec_q <= wdata;
			end
		end
	end

	always_comb begin
		nxt = carry_in;
		eligible = ctx.stack_empty ||
			(ctx.top_level > vic_pkg::LEVEL_W'(IDX));
		if (eligible && ctl_q[vic_pkg::CTL_ENABLE_BIT]) begin
			nxt.nonvect = carry_in.nonvect | (32'd1 << ctl_q[4:0]);
			if (!carry_in.found && ctx.irqs[ctl_q[4:0]]) begin
				nxt.found = 1'b1;
				nxt.level = vic_pkg::LEVEL_W'(IDX);
				nxt.vec = vec_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= nxt;
	end

	assign carry_out = carry_q;
	assign ctl = ctl_q;
	assign vec = vec_q;

endmodule

// File: rtl/core/vectored_interrupt_controller_top.sv
`timescale 1ns / 1ps

// Each request runs the priority scan through the row of slot cells, rippling one
// cell per cycle, once before and once after the access. The result is shown for
// one cycle with done, which the receiver cannot stall; busy is low again in that
// same cycle.

module vectored_interrupt_controller_top #(
	parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF,
	parameter int NUM_SLOTS = vic_pkg::NUM_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [9:0] word_addr,
	input logic [31:0] write_data,
	input logic [4:0] source_id,
	input logic source_level,
	input logic chain_fiq_n,
	input logic chain_irq,
	input logic [31:0] chain_vector,
	output logic done,
	output logic [31:0] read_data,
	output logic irq_n,
	output logic fiq_n,
	output logic [31:0] current_vector,
	output logic access_error
);

	localparam logic [31:0] SRC_MASK = 32'hffff_ffff >> (32 - NUM_SOURCES);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int KW = $clog2(vic_pkg::STACK_DEPTH + 1);
	localparam int TW = $clog2(vic_pkg::STACK_DEPTH);

	vic_pkg::state_t state_q;
	logic [CW-1:0] scan_q;
	logic [1:0] op_q;
	logic [9:0] addr_q;
	logic [31:0] wdata_q;
	logic [4:0] sid_q;
	logic slev_q;
	logic cfiq_n_q;
	logic cirq_q;
	logic [31:0] cvec_q;

	logic [31:0] src_q, soft_q, sel_q, en_q, defv_q, vout_q;
	logic pv_q;
	logic [vic_pkg::LEVEL_W-1:0] pl_q;
	logic [KW-1:0] cnt_q;
	logic [vic_pkg::LEVEL_W-1:0] stack_q [vic_pkg::STACK_DEPTH];
	logic [31:0] rd_q;
	logic err_q;

	logic [31:0] raw, fiqs, irqs;
	logic [TW-1:0] top_idx;
	vic_pkg::scan_ctx_t ctx;
	vic_pkg::carry_t carry [NUM_SLOTS+1];
	logic [5:0] ctl_arr [NUM_SLOTS];
	logic [31:0] vec_arr [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] wr_vec, wr_ctl;

	logic ev_pv, ev_found, ev_irqn, ev_fiqn;
	logic [vic_pkg::LEVEL_W-1:0] ev_pl;
	logic [31:0] ev_vo;
	logic scan_end;

	logic slot_hit;
	logic [SW-1:0] slot_idx;
	logic [31:0] acc_rd;
	logic acc_err;

	assign raw = (soft_q | src_q) & SRC_MASK;
	assign fiqs = raw & en_q & sel_q;
	assign irqs = raw & en_q & ~sel_q;
	assign top_idx = TW'(cnt_q - KW'(1));

	always_comb begin
		ctx.irqs = irqs;
		ctx.stack_empty = (cnt_q == '0);
		ctx.top_level = ctx.stack_empty ? '0 : stack_q[top_idx];
	end

	assign carry[0] = '0;
	assign slot_hit = (addr_q[5:0] < 6'(NUM_SLOTS));
	assign slot_idx = addr_q[SW-1:0];

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		assign wr_vec[i] = (state_q == vic_pkg::ST_ACCESS) && (op_q == vic_pkg::OP_WRITE) &&
			(addr_q[9:6] == vic_pkg::SLOT_VEC_PAGE) && (addr_q[5:0] == 6'(i));
		assign wr_ctl[i] = (state_q == vic_pkg::ST_ACCESS) && (op_q == vic_pkg::OP_WRITE) &&
			(addr_q[9:6] == vic_pkg::SLOT_CTL_PAGE) && (addr_q[5:0] == 6'(i));
		vic_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr_vec(wr_vec[i]),
			.wr_ctl(wr_ctl[i]),
			.wdata(wdata_q),
			.ctx(ctx),
			.carry_in(carry[i]),
			.carry_out(carry[i+1]),
			.ctl(ctl_arr[i]),
			.vec(vec_arr[i])
		);
	end

	always_comb begin
		ev_found = carry[NUM_SLOTS].found;
		ev_pv = 1'b0;
		ev_pl = pl_q;
		ev_vo = vout_q;
		if (ev_found) begin
			ev_pv = 1'b1;
			ev_pl = carry[NUM_SLOTS].level;
			ev_vo = carry[NUM_SLOTS].vec;
		end
		if (ctx.stack_empty && !ev_found) begin
			ev_vo = defv_q;
			if ((irqs & ~carry[NUM_SLOTS].nonvect) != '0) begin
				ev_found = 1'b1;
				ev_pv = 1'b1;
				ev_pl = vic_pkg::LEVEL_W'(NUM_SLOTS);
			end
		end
		ev_irqn = 1'b1;
		if (ev_found) begin
			ev_irqn = 1'b0;
		end else if (cirq_q) begin
			ev_pv = 1'b1;
			ev_pl = vic_pkg::LEVEL_W'(NUM_SLOTS);
			ev_vo = cvec_q;
			ev_irqn = 1'b0;
		end
		ev_fiqn = !(!cfiq_n_q || (fiqs != '0));
	end

	always_comb begin
		acc_rd = '0;
		acc_err = 1'b0;
		if (addr_q == vic_pkg::REG_IRQ_STATUS) begin
			acc_rd = irqs;
		end else if (addr_q == vic_pkg::REG_FIQ_STATUS) begin
			acc_rd = fiqs;
		end else if (addr_q == vic_pkg::REG_RAW_STATUS) begin
			acc_rd = raw;
		end else if (addr_q == vic_pkg::REG_SELECT) begin
			acc_rd = sel_q;
		end else if (addr_q == vic_pkg::REG_ENABLE) begin
			acc_rd = en_q;
		end else if (addr_q == vic_pkg::REG_ENABLE_CLR || addr_q == vic_pkg::REG_SOFT_CLR) begin
			acc_rd = '0;
		end else if (addr_q == vic_pkg::REG_SOFT) begin
			acc_rd = soft_q;
		end else if (addr_q == vic_pkg::REG_VECT_ADDR) begin
			acc_rd = vout_q;
		end else if (addr_q == vic_pkg::REG_DEF_VECT) begin
			acc_rd = defv_q;
		end else if (addr_q[9:6] == vic_pkg::SLOT_VEC_PAGE && slot_hit) begin
			acc_rd = vec_arr[slot_idx];
		end else if (addr_q[9:6] == vic_pkg::SLOT_CTL_PAGE && slot_hit) begin
			acc_rd = {26'd0, ctl_arr[slot_idx]};
		end else if (addr_q[9:3] == vic_pkg::ID_PAGE) begin
			acc_rd = vic_pkg::id_byte(addr_q[2:0]);
		end else begin
			acc_err = 1'b1;
		end
	end

	assign scan_end = (scan_q == CW'(NUM_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vic_pkg::ST_IDLE;
			scan_q <= '0;
			src_q <= '0;
			soft_q <= '0;
			sel_q <= '0;
			en_q <= '0;
			defv_q <= '0;
			vout_q <= '0;
			pv_q <= 1'b0;
			pl_q <= '0;
			cnt_q <= '0;
			done <= 1'b0;
			for (int k = 0; k < vic_pkg::STACK_DEPTH; k++) begin
				stack_q[k] <= '0;
			end
		end else begin
			done <= (state_q == vic_pkg::ST_SCAN2) && scan_end;
			unique case (state_q)
				vic_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= vic_pkg::ST_SCAN1;
						scan_q <= '0;
					end
				end
				vic_pkg::ST_SCAN1, vic_pkg::ST_SCAN2: begin
					scan_q <= scan_q + CW'(1);
					if (scan_end) begin
						pv_q <= ev_pv;
						pl_q <= ev_pl;
						vout_q <= ev_vo;
						if (state_q == vic_pkg::ST_SCAN1) begin
							state_q <= vic_pkg::ST_ACCESS;
						end else begin
							state_q <= vic_pkg::ST_IDLE;
						end
					end
				end
				vic_pkg::ST_ACCESS: begin
					state_q <= vic_pkg::ST_SCAN2;
					scan_q <= '0;
					if (op_q == vic_pkg::OP_READ && addr_q == vic_pkg::REG_VECT_ADDR && pv_q) begin
						if (cnt_q < KW'(vic_pkg::STACK_DEPTH)) begin
							stack_q[TW'(cnt_q)] <= pl_q;
							cnt_q <= cnt_q + KW'(1);
						end
						pv_q <= 1'b0;
					end else if (op_q == vic_pkg::OP_WRITE) begin
						if (addr_q == vic_pkg::REG_SELECT) begin
							sel_q <= wdata_q & SRC_MASK;
						end else if (addr_q == vic_pkg::REG_ENABLE) begin
							en_q <= (en_q | wdata_q) & SRC_MASK;
						end else if (addr_q == vic_pkg::REG_ENABLE_CLR) begin
							en_q <= en_q & ~wdata_q;
						end else if (addr_q == vic_pkg::REG_SOFT) begin
							soft_q <= (soft_q | wdata_q) & SRC_MASK;
						end else if (addr_q == vic_pkg::REG_SOFT_CLR) begin
							soft_q <= soft_q & ~wdata_q;
						end else if (addr_q == vic_pkg::REG_VECT_ADDR) begin
							if (cnt_q != '0) begin
								cnt_q <= cnt_q - KW'(1);
								stack_q[top_idx] <= '0;
							end
						end else if (addr_q == vic_pkg::REG_DEF_VECT) begin
							defv_q <= wdata_q;
						end
					end else if (op_q == vic_pkg::OP_SOURCE) begin
						if (6'(sid_q) < 6'(NUM_SOURCES)) begin
							src_q[sid_q] <= slev_q;
						end
					end
				end
				default: state_q <= vic_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == vic_pkg::ST_IDLE && start) begin
			op_q <= opcode;
			addr_q <= word_addr;
			wdata_q <= write_data;
			sid_q <= source_id;
			slev_q <= source_level;
			cfiq_n_q <= chain_fiq_n;
			cirq_q <= chain_irq;
			cvec_q <= chain_vector;
		end
		if (state_q == vic_pkg::ST_ACCESS) begin
			rd_q <= (op_q == vic_pkg::OP_READ) ? acc_rd : '0;
			err_q <= (op_q == vic_pkg::OP_READ || op_q == vic_pkg::OP_WRITE) && acc_err;
		end
		if (state_q == vic_pkg::ST_SCAN2 && scan_end) begin
			read_data <= rd_q;
			access_error <= err_q;
			irq_n <= ev_irqn;
			fiq_n <= ev_fiqn;
			current_vector <= ev_vo;
		end
	end

	assign busy = (state_q != vic_pkg::ST_IDLE);

endmodule

// File: rtl/core/vic_checker.sv
`timescale 1ns / 1ps

module vic_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [31:0] read_data,
	input logic access_error
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted request");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && access_error |-> read_data == '0)
		else $error("nonzero read data on an access error");

endmodule

bind vectored_interrupt_controller_top vic_checker u_vic_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.read_data(read_data),
	.access_error(access_error)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [9:0] REG_SLOT_VEC = {vic_pkg::SLOT_VEC_PAGE, 6'd0};
	localparam logic [9:0] REG_SLOT_CTL = {vic_pkg::SLOT_CTL_PAGE, 6'd0};
	localparam logic [9:0] REG_ID = {vic_pkg::ID_PAGE, 3'd0};
	localparam int SLOTS = vic_pkg::NUM_SLOTS_DEF;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [31:0] read_data;
		logic irq_n;
		logic fiq_n;
		logic [31:0] vector;
		logic access_error;
	} vic_result_t;

	logic clk, arst_n, start, busy, done;
	logic [1:0] opcode;
	logic [9:0] word_addr;
	logic [31:0] write_data, chain_vector, read_data, current_vector;
	logic [4:0] source_id;
	logic source_level, chain_fiq_n, chain_irq, irq_n, fiq_n, access_error;

	vectored_interrupt_controller_top u_top (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the controller state.
	logic [31:0] sh_lines, sh_soft, sh_select, sh_enable, sh_default, sh_vector;
	logic [5:0] sh_slot_ctl [SLOTS];
	logic [31:0] sh_slot_vec [SLOTS];
	logic [4:0] sh_levels [vic_pkg::STACK_DEPTH];
	int sh_depth;
	logic sh_pending;
	logic [4:0] sh_pending_level;

	vic_result_t expected_results[$];
	int idle_pct;
	int failures;
	int stall_cycles;
	logic cur_fiq_n, cur_irq;

	function automatic void arbitrate(input logic cfn, input logic cirq, input logic [31:0] cvec,
			output logic o_irq_n, output logic o_fiq_n);
		logic [31:0] irqs, fiqs, nonvect;
		logic found, eligible;
		irqs = (sh_soft | sh_lines) & sh_enable & ~sh_select;
		fiqs = (sh_soft | sh_lines) & sh_enable & sh_select;
		nonvect = '0;
		found = 1'b0;
		o_fiq_n = !(!cfn || fiqs != 0);
		sh_pending = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			eligible = (sh_depth == 0) || (sh_levels[sh_depth - 1] > i);
			if (eligible && sh_slot_ctl[i][vic_pkg::CTL_ENABLE_BIT]) begin
				nonvect[sh_slot_ctl[i][4:0]] = 1'b1;
				if (!found && irqs[sh_slot_ctl[i][4:0]]) begin
					found = 1'b1;
					sh_pending = 1'b1;
					sh_pending_level = 5'(i);
					sh_vector = sh_slot_vec[i];
				end
			end
		end
		if (sh_depth == 0 && !found) begin
			sh_vector = sh_default;
			if ((irqs & ~nonvect) != 0) begin
				found = 1'b1;
				sh_pending = 1'b1;
				sh_pending_level = 5'(SLOTS);
			end
		end
		if (found) begin
			o_irq_n = 1'b0;
		end else if (cirq) begin
			sh_pending = 1'b1;
			sh_pending_level = 5'(SLOTS);
			sh_vector = cvec;
			o_irq_n = 1'b0;
		end else begin
			o_irq_n = 1'b1;
		end
	endfunction

	function automatic vic_result_t predict_outcome(input logic [1:0] op, input logic [9:0] w,
			input logic [31:0] d, input logic [4:0] sid, input logic slev, input logic cfn,
			input logic cirq, input logic [31:0] cvec);
		vic_result_t r;
		logic in_vec, in_ctl, in_id, mapped;
		r = '0;
		in_vec = w >= REG_SLOT_VEC && w < REG_SLOT_VEC + SLOTS;
		in_ctl = w >= REG_SLOT_CTL && w < REG_SLOT_CTL + SLOTS;
		in_id = w >= REG_ID;
		mapped = w <= vic_pkg::REG_SOFT_CLR || w == vic_pkg::REG_VECT_ADDR
			|| w == vic_pkg::REG_DEF_VECT || in_vec || in_ctl || in_id;
		arbitrate(cfn, cirq, cvec, r.irq_n, r.fiq_n);
		if ((op == vic_pkg::OP_READ || op == vic_pkg::OP_WRITE) && !mapped) begin
			r.access_error = 1'b1;
		end else if (op == vic_pkg::OP_READ) begin
			case (w)
				vic_pkg::REG_IRQ_STATUS:
					r.read_data = (sh_soft | sh_lines) & sh_enable & ~sh_select;
				vic_pkg::REG_FIQ_STATUS:
					r.read_data = (sh_soft | sh_lines) & sh_enable & sh_select;
				vic_pkg::REG_RAW_STATUS: r.read_data = sh_soft | sh_lines;
				vic_pkg::REG_SELECT: r.read_data = sh_select;
				vic_pkg::REG_ENABLE: r.read_data = sh_enable;
				vic_pkg::REG_SOFT: r.read_data = sh_soft;
				vic_pkg::REG_DEF_VECT: r.read_data = sh_default;
				vic_pkg::REG_VECT_ADDR: begin
					r.read_data = sh_vector;
					if (sh_pending) begin
						if (sh_depth < vic_pkg::STACK_DEPTH) begin
							sh_levels[sh_depth] = sh_pending_level;
							sh_depth++;
						end
						sh_pending = 1'b0;
					end
				end
				default: begin
					if (in_vec)
						r.read_data = sh_slot_vec[w - REG_SLOT_VEC];
					else if (in_ctl)
						r.read_data = {26'd0, sh_slot_ctl[w - REG_SLOT_CTL]};
					else if (in_id)
						case (w - REG_ID)
							0: r.read_data = 32'h90;
							1: r.read_data = 32'h11;
							2: r.read_data = 32'h04;
							4: r.read_data = 32'h0d;
							5: r.read_data = 32'hf0;
							6: r.read_data = 32'h05;
							7: r.read_data = 32'hb1;
							default: r.read_data = 32'h00;
						endcase
				end
			endcase
		end else if (op == vic_pkg::OP_WRITE) begin
			case (w)
				vic_pkg::REG_SELECT: sh_select = d;
				vic_pkg::REG_ENABLE: sh_enable |= d;
				vic_pkg::REG_ENABLE_CLR: sh_enable &= ~d;
				vic_pkg::REG_SOFT: sh_soft |= d;
				vic_pkg::REG_SOFT_CLR: sh_soft &= ~d;
				vic_pkg::REG_DEF_VECT: sh_default = d;
				vic_pkg::REG_VECT_ADDR: begin
					if (sh_depth != 0) begin
						sh_depth--;
						sh_levels[sh_depth] = '0;
					end
				end
				default: begin
					if (in_vec)
						sh_slot_vec[w - REG_SLOT_VEC] = d;
					else if (in_ctl)
						sh_slot_ctl[w - REG_SLOT_CTL] = d[5:0];
				end
			endcase
		end else if (op == vic_pkg::OP_SOURCE) begin
			sh_lines[sid] = slev;
		end
		arbitrate(cfn, cirq, cvec, r.irq_n, r.fiq_n);
		r.vector = sh_vector;
		return r;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [9:0] w, input logic [31:0] d,
			input logic [4:0] sid, input logic slev, input logic cfn, input logic cirq,
			input logic [31:0] cvec);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		opcode <= op;
		word_addr <= w;
		write_data <= d;
		source_id <= sid;
		source_level <= slev;
		chain_fiq_n <= cfn;
		chain_irq <= cirq;
		chain_vector <= cvec;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_outcome(op, w, d, sid, slev, cfn, cirq, cvec));
	endtask

	task automatic reg_write(input logic [9:0] w, input logic [31:0] d);
		send_request(vic_pkg::OP_WRITE, w, d, 5'($urandom), 1'($urandom), cur_fiq_n, cur_irq,
			$urandom);
	endtask

	task automatic reg_read(input logic [9:0] w);
		send_request(vic_pkg::OP_READ, w, $urandom, 5'($urandom), 1'($urandom), cur_fiq_n,
			cur_irq, $urandom);
	endtask

	task automatic set_line(input logic [4:0] sid, input logic slev);
		send_request(vic_pkg::OP_SOURCE, 10'($urandom), $urandom, sid, slev, cur_fiq_n, cur_irq,
			$urandom);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		wait (expected_results.size() == 0);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		vic_result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				e = expected_results.pop_front();
				if (read_data !== e.read_data) begin
					$error("read_data expected %h got %h", e.read_data, read_data);
					failures++;
				end
				if (irq_n !== e.irq_n) begin
					$error("irq_n expected %b got %b", e.irq_n, irq_n);
					failures++;
				end
				if (fiq_n !== e.fiq_n) begin
					$error("fiq_n expected %b got %b", e.fiq_n, fiq_n);
					failures++;
				end
				if (current_vector !== e.vector) begin
					$error("current_vector expected %h got %h", e.vector, current_vector);
					failures++;
				end
				if (access_error !== e.access_error) begin
					$error("access_error expected %b got %b", e.access_error, access_error);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_register_map();
		reg_read(REG_ID);
		reg_read(REG_ID + 10'd7);
		reg_read(10'd8);
		reg_write(10'd1023 - 10'd64, 32'hffff_ffff);
		reg_write(vic_pkg::REG_RAW_STATUS, 32'hffff_ffff);
		reg_read(vic_pkg::REG_ENABLE_CLR);
		reg_read(vic_pkg::REG_SOFT_CLR);
		reg_write(10'(REG_SLOT_VEC + SLOTS - 1), 32'hffff_ffff);
		reg_read(10'(REG_SLOT_VEC + SLOTS - 1));
		reg_read(10'(REG_SLOT_VEC + SLOTS));
		reg_write(10'(REG_SLOT_CTL + SLOTS - 1), 32'hffff_ffff);
		reg_read(10'(REG_SLOT_CTL + SLOTS - 1));
		send_request(OP_NONE, '1, '1, '1, 1'b1, 1'b1, 1'b0, '1);
	endtask

	task automatic test_status_masks();
		reg_write(vic_pkg::REG_SELECT, 32'h8000_0001);
		reg_write(vic_pkg::REG_ENABLE, 32'hffff_ffff);
		reg_write(vic_pkg::REG_SOFT, 32'h0000_0001);
		reg_read(vic_pkg::REG_FIQ_STATUS);
		set_line(5'd31, 1'b1);
		set_line(5'd4, 1'b1);
		reg_read(vic_pkg::REG_IRQ_STATUS);
		reg_read(vic_pkg::REG_RAW_STATUS);
		reg_write(vic_pkg::REG_SOFT_CLR, 32'hffff_ffff);
		reg_write(vic_pkg::REG_ENABLE_CLR, 32'h8000_0000);
		reg_read(vic_pkg::REG_ENABLE);
		reg_write(vic_pkg::REG_DEF_VECT, 32'hdead_0000);
		reg_read(vic_pkg::REG_VECT_ADDR);
		reg_write(vic_pkg::REG_VECT_ADDR, 32'h0);
		reg_write(vic_pkg::REG_VECT_ADDR, 32'h0);
	endtask

	task automatic test_vector_nesting();
		reg_write(REG_SLOT_VEC + 10'd3, 32'h0000_3000);
		reg_write(REG_SLOT_CTL + 10'd3, 32'h24);
		reg_write(REG_SLOT_VEC, 32'h0000_0100);
		reg_write(REG_SLOT_CTL, 32'h25);
		reg_read(vic_pkg::REG_VECT_ADDR);
		reg_read(vic_pkg::REG_VECT_ADDR);
		set_line(5'd5, 1'b1);
		reg_read(vic_pkg::REG_VECT_ADDR);
		reg_write(vic_pkg::REG_VECT_ADDR, 32'h0);
		reg_write(vic_pkg::REG_VECT_ADDR, 32'h0);
		set_line(5'd5, 1'b0);
		set_line(5'd4, 1'b0);
	endtask

	task automatic test_chain_overflow();
		cur_fiq_n = 1'b0;
		cur_irq = 1'b1;
		reg_write(vic_pkg::REG_ENABLE_CLR, 32'hffff_ffff);
		repeat (vic_pkg::STACK_DEPTH + 2) reg_read(vic_pkg::REG_VECT_ADDR);
		cur_fiq_n = 1'b1;
		cur_irq = 1'b0;
		repeat (vic_pkg::STACK_DEPTH + 2) reg_write(vic_pkg::REG_VECT_ADDR, 32'h0);
	endtask

	task automatic random_requests(input int count);
		int r;
		logic [9:0] w;
		logic cfn, cirq;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			cfn = $urandom_range(9) != 0;
			cirq = $urandom_range(4) == 0;
			if (r < 25) begin
				send_request(vic_pkg::OP_SOURCE, 10'($urandom), $urandom, 5'($urandom),
					1'($urandom), cfn, cirq, $urandom);
			end else if (r < 45) begin
				w = ($urandom_range(1) ? REG_SLOT_CTL : REG_SLOT_VEC)
					+ 10'($urandom_range(SLOTS - 1));
				send_request(vic_pkg::OP_WRITE, w,
					$urandom | ($urandom_range(3) != 0 ? 32'h20 : 32'h0),
					5'($urandom), 1'($urandom), cfn, cirq, $urandom);
			end else if (r < 60) begin
				w = 10'($urandom_range(vic_pkg::REG_SELECT, vic_pkg::REG_SOFT_CLR));
				if ($urandom_range(5) == 0)
					w = vic_pkg::REG_DEF_VECT;
				send_request(vic_pkg::OP_WRITE, w, $urandom, 5'($urandom), 1'($urandom), cfn,
					cirq, $urandom);
			end else if (r < 75) begin
				send_request(vic_pkg::OP_READ, vic_pkg::REG_VECT_ADDR, $urandom, 5'($urandom),
					1'($urandom), cfn, cirq, $urandom);
			end else if (r < 85) begin
				send_request(vic_pkg::OP_WRITE, vic_pkg::REG_VECT_ADDR, $urandom, 5'($urandom),
					1'($urandom), cfn, cirq, $urandom);
			end else if (r < 93) begin
				w = $urandom_range(1) ? 10'($urandom_range(vic_pkg::REG_DEF_VECT))
					: REG_SLOT_VEC + 10'($urandom_range(95));
				send_request(vic_pkg::OP_READ, w, $urandom, 5'($urandom), 1'($urandom), cfn,
					cirq, $urandom);
			end else begin
				send_request(2'($urandom), 10'($urandom), $urandom, 5'($urandom), 1'($urandom),
					1'($urandom), 1'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = vic_pkg::OP_READ;
		word_addr = '0;
		write_data = '0;
		source_id = '0;
		source_level = 1'b0;
		chain_fiq_n = 1'b1;
		chain_irq = 1'b0;
		chain_vector = '0;
		sh_lines = '0;
		sh_soft = '0;
		sh_select = '0;
		sh_enable = '0;
		sh_default = '0;
		sh_vector = '0;
		for (int i = 0; i < SLOTS; i++) begin
			sh_slot_ctl[i] = '0;
			sh_slot_vec[i] = '0;
		end
		for (int i = 0; i < vic_pkg::STACK_DEPTH; i++)
			sh_levels[i] = '0;
		sh_depth = 0;
		sh_pending = 1'b0;
		sh_pending_level = '0;
		failures = 0;
		stall_cycles = 0;
		idle_pct = 0;
		cur_fiq_n = 1'b1;
		cur_irq = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_map();
		test_status_masks();
		test_vector_nesting();
		test_chain_overflow();
		wait_drained();

		idle_pct = 0;
		random_requests(125);
		idle_pct = 76;
		random_requests(125);
		wait_drained();
		idle_pct = 8;
		random_requests(125);

		wait_drained();
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/vic_pkg.sv
rtl/core/vic_cell.sv
rtl/core/vectored_interrupt_controller_top.sv
rtl/core/vic_checker.sv
tb/tb_top.sv
